/* src/sll_pkg.sv */
// Shared types, constants and helper functions for the stack language lexer.
`default_nettype none

package sll_pkg;

   // Field widths.
   localparam int OFFSET_BITS   = 24;
   localparam int POSITION_BITS = 16;
   localparam int KIND_BITS     = 5;
   localparam int STATUS_BITS   = 2;
   localparam int MODE_BITS     = 4;

   // Depth of the token group queue between the scanner and the emitter.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Scanner modes.
   localparam logic [MODE_BITS-1:0] MODE_IDLE    = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_MINUS   = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_LT      = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_SLASH   = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_COMMENT = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_STRING  = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_NUMBER  = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_WORD    = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_HALT    = 4'd8;

   // Token kinds.
   localparam logic [KIND_BITS-1:0] K_PLUS   = 5'd0;
   localparam logic [KIND_BITS-1:0] K_MINUS  = 5'd1;
   localparam logic [KIND_BITS-1:0] K_MULT   = 5'd2;
   localparam logic [KIND_BITS-1:0] K_DIV    = 5'd3;
   localparam logic [KIND_BITS-1:0] K_MOD    = 5'd4;
   localparam logic [KIND_BITS-1:0] K_LT     = 5'd5;
   localparam logic [KIND_BITS-1:0] K_GT     = 5'd6;
   localparam logic [KIND_BITS-1:0] K_EQ     = 5'd7;
   localparam logic [KIND_BITS-1:0] K_NUMBER = 5'd8;
   localparam logic [KIND_BITS-1:0] K_STRING = 5'd9;
   localparam logic [KIND_BITS-1:0] K_DUMP   = 5'd10;
   localparam logic [KIND_BITS-1:0] K_BDUMP  = 5'd11;
   localparam logic [KIND_BITS-1:0] K_DUP    = 5'd12;
   localparam logic [KIND_BITS-1:0] K_TWODUP = 5'd13;
   localparam logic [KIND_BITS-1:0] K_DROP   = 5'd14;
   localparam logic [KIND_BITS-1:0] K_SWAP   = 5'd15;
   localparam logic [KIND_BITS-1:0] K_STASH  = 5'd16;
   localparam logic [KIND_BITS-1:0] K_POP    = 5'd17;
   localparam logic [KIND_BITS-1:0] K_WORD   = 5'd18;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_TOKEN     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_UNHANDLED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OPEN_STR  = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // One result item.
   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [STATUS_BITS-1:0]   status;
      logic [OFFSET_BITS-1:0]   start;
      logic [OFFSET_BITS-1:0]   length;
      logic [POSITION_BITS-1:0] column;
      logic [POSITION_BITS-1:0] line;
   } token_type;

   // All results caused by one source byte: one or two tokens.
   typedef struct packed {
      token_type first;
      token_type second;
      logic      two;
   } group_type;

   // Saturating increments.
   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (v == {OFFSET_BITS{1'b1}}) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [POSITION_BITS-1:0] v);
      return (v == {POSITION_BITS{1'b1}}) ? v : v + POSITION_BITS'(1);
   endfunction

endpackage

`default_nettype wire

/* src/stack_language_lexer.sv */
// Top level of the stack language lexer: scanner, group queue and emitter.
//
// Usage: source bytes enter through a queue-like port. A transaction is taken
// at a clock edge where req_push is high and req_full is low; req_end_of_text
// marks the final byte of a text and flushes any open token. Results leave
// through a second queue-like port: while rsp_empty is low the oldest result
// is on the rsp_ ports, and it is taken at an edge where rsp_pop is high.
// Each byte yields zero, one or two results; rsp_last_of_run marks the last.
// Throughput: one byte per cycle on the input while req_full is low, and one
// result per cycle on the output while rsp_pop is high. A byte's first result
// reaches the rsp_ ports through the group queue, written at the accepting
// edge, and then the emitter's output register, loaded once that is free.
// When the receiver stalls, results collect in a four-group queue and the
// input keeps taking bytes until that queue is full; req_full then rises.
// An unhandled byte reports an error and halts the scanner: later bytes are
// still taken but give no results until reset.
// Reset (synchronous, active high) clears the queue and output, and returns
// the scanner to idle at offset 0, column 1, line 1.
`default_nettype none

module stack_language_lexer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [7:0]                        req_source_byte,
   input  wire logic                              req_end_of_text,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [sll_pkg::KIND_BITS-1:0]          rsp_token_kind,
   output logic [sll_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [sll_pkg::OFFSET_BITS-1:0]        rsp_start_offset,
   output logic [sll_pkg::OFFSET_BITS-1:0]        rsp_text_length,
   output logic [sll_pkg::POSITION_BITS-1:0]      rsp_column,
   output logic [sll_pkg::POSITION_BITS-1:0]      rsp_line,
   output logic                                   rsp_last_of_run
);
   import sll_pkg::*;

   logic      accept;
   logic      group_valid;
   group_type group;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   group_type q_head;
   logic      out_valid;
   token_type out_tok;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // Scanner.
   sll_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (accept),
      .source_byte (req_source_byte),
      .end_of_text (req_end_of_text),
      .group_valid (group_valid),
      .group       (group)
   );

   // Queue of result groups.
   sll_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (group_valid),
      .push_data (group),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Emitter.
   sll_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_tok   (out_tok),
      .out_last  (rsp_last_of_run),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_token_kind   = out_tok.kind;
   assign rsp_status       = out_tok.status;
   assign rsp_start_offset = out_tok.start;
   assign rsp_text_length  = out_tok.length;
   assign rsp_column       = out_tok.column;
   assign rsp_line         = out_tok.line;

endmodule

`default_nettype wire

/* src/sll_front.sv */
// Scanner: consumes one source byte per transaction and forms the tokens it closes.
`default_nettype none

module sll_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         source_byte,
   input  wire logic               end_of_text,
   output logic                    group_valid,
   output sll_pkg::group_type      group
);
   import sll_pkg::*;

   logic [MODE_BITS-1:0]     mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]   ostart_ff, ostart_in;
   logic [OFFSET_BITS-1:0]   olen_ff, olen_in;
   logic [POSITION_BITS-1:0] ocol_ff, ocol_in;
   logic [POSITION_BITS-1:0] oline_ff, oline_in;
   logic [POSITION_BITS-1:0] ccol_ff, ccol_in;
   logic [POSITION_BITS-1:0] cline_ff, cline_in;

   token_type                emit_tok [2];
   logic [1:0]               emit_cnt;
   logic                     go;
   logic                     single_hit;
   logic [KIND_BITS-1:0]     single_k;
   logic                     is_digit;
   logic                     is_alpha;

   function automatic token_type make_token(
      input logic [KIND_BITS-1:0]     kind,
      input logic [STATUS_BITS-1:0]   status,
      input logic [OFFSET_BITS-1:0]   start,
      input logic [OFFSET_BITS-1:0]   length,
      input logic [POSITION_BITS-1:0] column,
      input logic [POSITION_BITS-1:0] line
   );
      token_type t;
      t.kind   = kind;
      t.status = status;
      t.start  = start;
      t.length = length;
      t.column = column;
      t.line   = line;
      return t;
   endfunction

   // Byte classes.
   assign is_digit = (source_byte >= 8'h30) && (source_byte <= 8'h39);
   assign is_alpha = ((source_byte >= 8'h41) && (source_byte <= 8'h5A)) ||
                     ((source_byte >= 8'h61) && (source_byte <= 8'h7A));

   // Single-byte operators.
   always_comb begin
      single_hit = 1'b1;
      single_k   = K_PLUS;
      unique case (source_byte)
         CH_PLUS:  single_k = K_PLUS;
         CH_STAR:  single_k = K_MULT;
         CH_PCT:   single_k = K_MOD;
         CH_GT:    single_k = K_GT;
         CH_EQ:    single_k = K_EQ;
         CH_QMARK: single_k = K_DUMP;
         CH_BANG:  single_k = K_BDUMP;
         CH_DOT:   single_k = K_DUP;
         CH_COLON: single_k = K_TWODUP;
         CH_COMMA: single_k = K_DROP;
         CH_SEMI:  single_k = K_SWAP;
         default:  single_hit = 1'b0;
      endcase
   end

   // Next state and emitted tokens for the byte on the input.
   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      ostart_in   = ostart_ff;
      olen_in     = olen_ff;
      ocol_in     = ocol_ff;
      oline_in    = oline_ff;
      ccol_in     = ccol_ff;
      cline_in    = cline_ff;
      emit_tok[0] = '0;
      emit_tok[1] = '0;
      emit_cnt    = 2'd0;
      go          = 1'b0;

      if (byte_valid && (mode_ff != MODE_HALT)) begin
         // Close or extend the open token.
         unique case (mode_ff)
            MODE_STRING: begin
               if (source_byte == CH_QUOTE) begin
                  emit_tok[emit_cnt[0]] = make_token(K_STRING, ST_TOKEN, ostart_in, olen_in,
                                                     ocol_in, oline_in);
                  emit_cnt = emit_cnt + 2'd1;
                  mode_in  = MODE_IDLE;
               end else begin
                  olen_in = sat_off(olen_in);
               end
               ccol_in = sat_pos(ccol_in);
            end
            MODE_COMMENT: begin
               if (source_byte == CH_LF) begin
                  mode_in = MODE_IDLE;
                  go      = 1'b1;
               end else begin
                  ccol_in = sat_pos(ccol_in);
               end
            end
            MODE_MINUS, MODE_LT: begin
               if ((mode_ff == MODE_MINUS && source_byte == CH_GT) ||
                   (mode_ff == MODE_LT && source_byte == CH_MINUS)) begin
                  olen_in = OFFSET_BITS'(2);
                  emit_tok[emit_cnt[0]] = make_token((mode_ff == MODE_MINUS) ? K_POP : K_STASH,
                                                     ST_TOKEN, ostart_in, olen_in,
                                                     ocol_in, oline_in);
                  emit_cnt = emit_cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  ccol_in  = sat_pos(ccol_in);
               end else begin
                  emit_tok[emit_cnt[0]] = make_token((mode_ff == MODE_MINUS) ? K_MINUS : K_LT,
                                                     ST_TOKEN, ostart_in, olen_in,
                                                     ocol_in, oline_in);
                  emit_cnt = emit_cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  go       = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (source_byte == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
                  ccol_in = sat_pos(ccol_in);
               end else begin
                  emit_tok[emit_cnt[0]] = make_token(K_DIV, ST_TOKEN, ostart_in, olen_in,
                                                     ocol_in, oline_in);
                  emit_cnt = emit_cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  go       = 1'b1;
               end
            end
            MODE_NUMBER, MODE_WORD: begin
               if ((mode_ff == MODE_NUMBER) ? is_digit : is_alpha) begin
                  olen_in = sat_off(olen_in);
                  ccol_in = sat_pos(ccol_in);
               end else begin
                  emit_tok[emit_cnt[0]] = make_token((mode_ff == MODE_NUMBER) ? K_NUMBER : K_WORD,
                                                     ST_TOKEN, ostart_in, olen_in,
                                                     ocol_in, oline_in);
                  emit_cnt = emit_cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  go       = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               go      = 1'b1;
            end
         endcase

         // Start a new token from this byte when nothing holds it.
         if (go) begin
            priority if (single_hit) begin
               emit_tok[emit_cnt[0]] = make_token(single_k, ST_TOKEN, pos_ff, OFFSET_BITS'(1),
                                                  ccol_in, cline_in);
               emit_cnt = emit_cnt + 2'd1;
               ccol_in  = sat_pos(ccol_in);
            end else if (source_byte == CH_QUOTE) begin
               mode_in   = MODE_STRING;
               ostart_in = sat_off(pos_ff);
               olen_in   = '0;
               ocol_in   = ccol_in;
               oline_in  = cline_in;
               ccol_in   = sat_pos(ccol_in);
            end else if (source_byte == CH_MINUS || source_byte == CH_LT ||
                         source_byte == CH_SLASH) begin
               mode_in   = (source_byte == CH_MINUS) ? MODE_MINUS :
                           ((source_byte == CH_LT) ? MODE_LT : MODE_SLASH);
               ostart_in = pos_ff;
               olen_in   = OFFSET_BITS'(1);
               ocol_in   = ccol_in;
               oline_in  = cline_in;
               ccol_in   = sat_pos(ccol_in);
            end else if (source_byte == CH_SPACE || source_byte == CH_TAB) begin
               ccol_in = sat_pos(ccol_in);
            end else if (source_byte == CH_LF || source_byte == CH_CR) begin
               ccol_in  = POSITION_BITS'(1);
               cline_in = sat_pos(cline_in);
            end else if (is_digit || is_alpha) begin
               mode_in   = is_digit ? MODE_NUMBER : MODE_WORD;
               ostart_in = pos_ff;
               olen_in   = OFFSET_BITS'(1);
               ocol_in   = ccol_in;
               oline_in  = cline_in;
               ccol_in   = sat_pos(ccol_in);
            end else begin
               emit_tok[emit_cnt[0]] = make_token(K_PLUS, ST_UNHANDLED, pos_ff,
                                                  OFFSET_BITS'(1), ccol_in, cline_in);
               emit_cnt = emit_cnt + 2'd1;
               mode_in  = MODE_HALT;
            end
         end

         pos_in = sat_off(pos_ff);

         // End of text: flush the open token and return to the reset state.
         if (end_of_text && (mode_in != MODE_HALT)) begin
            if (mode_in == MODE_MINUS || mode_in == MODE_LT || mode_in == MODE_SLASH ||
                mode_in == MODE_NUMBER || mode_in == MODE_WORD) begin
               emit_tok[emit_cnt[0]] = make_token(
                  (mode_in == MODE_MINUS) ? K_MINUS :
                  (mode_in == MODE_LT) ? K_LT :
                  (mode_in == MODE_SLASH) ? K_DIV :
                  (mode_in == MODE_NUMBER) ? K_NUMBER : K_WORD,
                  ST_TOKEN, ostart_in, olen_in, ocol_in, oline_in);
               emit_cnt = emit_cnt + 2'd1;
            end else if (mode_in == MODE_STRING) begin
               emit_tok[emit_cnt[0]] = make_token(K_PLUS, ST_OPEN_STR, ostart_in, olen_in,
                                                  ocol_in, oline_in);
               emit_cnt = emit_cnt + 2'd1;
            end
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            ostart_in = '0;
            olen_in   = '0;
            ocol_in   = POSITION_BITS'(1);
            oline_in  = POSITION_BITS'(1);
            ccol_in   = POSITION_BITS'(1);
            cline_in  = POSITION_BITS'(1);
         end
      end
   end

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         ostart_ff <= '0;
         olen_ff   <= '0;
         ocol_ff   <= POSITION_BITS'(1);
         oline_ff  <= POSITION_BITS'(1);
         ccol_ff   <= POSITION_BITS'(1);
         cline_ff  <= POSITION_BITS'(1);
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         ostart_ff <= ostart_in;
         olen_ff   <= olen_in;
         ocol_ff   <= ocol_in;
         oline_ff  <= oline_in;
         ccol_ff   <= ccol_in;
         cline_ff  <= cline_in;
      end
   end

   // Group of results for the queue.
   assign group_valid  = (emit_cnt != 2'd0);
   assign group.first  = emit_tok[0];
   assign group.second = emit_tok[1];
   assign group.two    = emit_cnt[1];

endmodule

`default_nettype wire

/* src/sll_queue.sv */
// Short queue of token groups between the scanner and the emitter.
`default_nettype none

module sll_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sll_pkg::group_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output sll_pkg::group_type      head
);
   import sll_pkg::*;

   group_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = push ? wr_ff + QPTR_BITS'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_BITS'(1) : rd_ff;
      count_in = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + (QPTR_BITS+1)'(1)))
      else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

/* src/sll_back.sv */
// Emitter: takes token groups from the queue and presents them one result at a time.
`default_nettype none

module sll_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire sll_pkg::group_type q_head,
   output logic                    q_pop,
   output logic                    out_valid,
   output sll_pkg::token_type      out_tok,
   output logic                    out_last,
   input  wire logic               out_pop
);
   import sll_pkg::*;

   logic      valid_ff, valid_in;
   logic      pend_ff, pend_in;
   logic      last_ff, last_in;
   token_type tok_ff, tok_in;
   token_type pend_tok_ff, pend_tok_in;
   logic      free;

   // The output register can load when it is empty or being taken.
   assign free = !valid_ff || out_pop;

   always_comb begin
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      last_in     = last_ff;
      tok_in      = tok_ff;
      pend_tok_in = pend_tok_ff;
      q_pop       = 1'b0;
      if (free) begin
         priority if (pend_ff) begin
            valid_in = 1'b1;
            tok_in   = pend_tok_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (!q_empty) begin
            valid_in    = 1'b1;
            tok_in      = q_head.first;
            last_in     = !q_head.two;
            pend_in     = q_head.two;
            pend_tok_in = q_head.second;
            q_pop       = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      tok_ff      <= tok_in;
      pend_tok_ff <= pend_tok_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

`ifndef NO_ASSERTIONS
   a_pend_behind_first: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (valid_ff && !last_ff))
      else $error("second token pending without a first one shown");
   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && out_pop) |=> (valid_ff && last_ff))
      else $error("second token of a group not marked last");
   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !q_pop)
      else $error("queue read while a second token waits");
`endif

endmodule

`default_nettype wire
